FILE: hdl/cau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types, opcodes and helpers for the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int unsigned FracBitsDefault = 8;
  localparam int unsigned QuoBits         = 16;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } cau_op_e;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] a_real;
    logic signed [15:0] a_imag;
    logic signed [15:0] b_real;
    logic signed [15:0] b_imag;
  } cau_req_t;

  typedef struct packed {
    logic signed [15:0] res_real;
    logic signed [15:0] res_imag;
    logic               mag_less;
    logic               mag_greater;
    logic               same_value;
    logic               div_by_zero;
    logic               saturated;
  } cau_rsp_t;

  // Side data that travels along the divider chain
  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] rr;     // non-divide result, already clipped
    logic signed [15:0] ri;
    logic               sat;
    logic               ml;
    logic               mg;
    logic               eq;
    logic               dz;
    logic               neg_r;  // divide quotient signs
    logic               neg_i;
    logic               ovf_r;  // quotient magnitude >= 2^16
    logic               ovf_i;
  } cau_side_t;

  // Clip a 33-bit signed value to 16 bits; MSB of result is the clip flag
  function automatic logic [16:0] clip33(input logic signed [32:0] v);
    logic [16:0] r;
    if (v > 33'sd32767) begin
      r = {1'b1, 16'h7FFF};
    end else if (v < -33'sd32768) begin
      r = {1'b1, 16'h8000};
    end else begin
      r = {1'b0, v[15:0]};
    end
    return r;
  endfunction

endpackage

FILE: hdl/cau_prep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_prep
// Front pipeline: products, sums, flags, non-divide results, divider setup.
// ----------------------------------------------------------------------------
module cau_prep import cau_pkg::*; #(
  parameter int unsigned FRAC_BITS = FracBitsDefault,
  parameter int unsigned RW        = 48
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  cau_req_t        req_i,
  output logic            valid_o,
  output cau_side_t       side_o,
  output logic [31:0]     d_o,
  output logic [RW-1:0]   rem_r_o,
  output logic [RW-1:0]   rem_i_o
);

  // stage 1: products
  logic               v1_q;
  cau_req_t           req1_q;
  logic signed [31:0] p_arbr_q, p_aibi_q, p_arbi_q, p_aibr_q;
  logic signed [31:0] p_arar_q, p_aiai_q, p_brbr_q, p_bibi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      req1_q   <= req_i;
      p_arbr_q <= req_i.a_real * req_i.b_real;
      p_aibi_q <= req_i.a_imag * req_i.b_imag;
      p_arbi_q <= req_i.a_real * req_i.b_imag;
      p_aibr_q <= req_i.a_imag * req_i.b_real;
      p_arar_q <= req_i.a_real * req_i.a_real;
      p_aiai_q <= req_i.a_imag * req_i.a_imag;
      p_brbr_q <= req_i.b_real * req_i.b_real;
      p_bibi_q <= req_i.b_imag * req_i.b_imag;
    end
  end

  // stage 2: sums, flags, non-divide results
  logic signed [32:0] mr, mi, nr, ni, sr, si;
  logic [31:0]        ma, mb;
  logic [16:0]        cr, ci;
  cau_side_t          side2_d, side2_q;
  logic               v2_q;
  logic [31:0]        d2_q, magr_q, magi_q;
  logic [32:0]        magr, magi;

  always_comb begin
    mr = 33'(p_arbr_q) - 33'(p_aibi_q);
    mi = 33'(p_arbi_q) + 33'(p_aibr_q);
    nr = 33'(p_arbr_q) + 33'(p_aibi_q);
    ni = 33'(p_aibr_q) - 33'(p_arbi_q);
    ma = 32'(p_arar_q) + 32'(p_aiai_q);
    mb = 32'(p_brbr_q) + 32'(p_bibi_q);
    unique case (cau_op_e'(req1_q.kind))
      OP_ADD: begin
        sr = 33'(req1_q.a_real) + 33'(req1_q.b_real);
        si = 33'(req1_q.a_imag) + 33'(req1_q.b_imag);
      end
      OP_SUB: begin
        sr = 33'(req1_q.a_real) - 33'(req1_q.b_real);
        si = 33'(req1_q.a_imag) - 33'(req1_q.b_imag);
      end
      default: begin
        sr = mr >>> FRAC_BITS;
        si = mi >>> FRAC_BITS;
      end
    endcase
    cr = clip33(sr);
    ci = clip33(si);
    magr = nr[32] ? -nr : nr;
    magi = ni[32] ? -ni : ni;
    side2_d       = '0;
    side2_d.kind  = req1_q.kind;
    side2_d.rr    = cr[15:0];
    side2_d.ri    = ci[15:0];
    side2_d.sat   = cr[16] | ci[16];
    side2_d.ml    = ma < mb;
    side2_d.mg    = ma > mb;
    side2_d.eq    = (req1_q.a_real == req1_q.b_real) && (req1_q.a_imag == req1_q.b_imag);
    side2_d.dz    = (cau_op_e'(req1_q.kind) == OP_DIV) && (mb == 32'd0);
    side2_d.neg_r = nr[32];
    side2_d.neg_i = ni[32];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side2_q <= side2_d;
      d2_q    <= mb;
      magr_q  <= magr[31:0];
      magi_q  <= magi[31:0];
    end
  end

  // stage 3: scale numerators, detect quotient overflow
  logic [RW-1:0] n_r, n_i, dsh;
  cau_side_t     side3_d, side3_q;
  logic          v3_q;
  logic [31:0]   d3_q;
  logic [RW-1:0] rem_r_q, rem_i_q;

  always_comb begin
    n_r = RW'(magr_q) << FRAC_BITS;
    n_i = RW'(magi_q) << FRAC_BITS;
    dsh = RW'(d2_q) << QuoBits;
    side3_d       = side2_q;
    side3_d.ovf_r = n_r >= dsh;
    side3_d.ovf_i = n_i >= dsh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side3_q <= side3_d;
      d3_q    <= d2_q;
      rem_r_q <= n_r;
      rem_i_q <= n_i;
    end
  end

  assign valid_o = v3_q;
  assign side_o  = side3_q;
  assign d_o     = d3_q;
  assign rem_r_o = rem_r_q;
  assign rem_i_o = rem_i_q;

endmodule

FILE: hdl/cau_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_div_cell
// One restoring-division cell: resolves quotient bit K for both components.
// ----------------------------------------------------------------------------
module cau_div_cell import cau_pkg::*; #(
  parameter int unsigned RW = 48,
  parameter int unsigned K  = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  cau_side_t          side_i,
  input  logic [31:0]        d_i,
  input  logic [RW-1:0]      rem_r_i,
  input  logic [RW-1:0]      rem_i_i,
  input  logic [QuoBits-1:0] q_r_i,
  input  logic [QuoBits-1:0] q_i_i,
  output logic               valid_o,
  output cau_side_t          side_o,
  output logic [31:0]        d_o,
  output logic [RW-1:0]      rem_r_o,
  output logic [RW-1:0]      rem_i_o,
  output logic [QuoBits-1:0] q_r_o,
  output logic [QuoBits-1:0] q_i_o
);

  logic [RW-1:0]      dk, rem_r_d, rem_i_d;
  logic [QuoBits-1:0] q_r_d, q_i_d;
  logic               valid_q;
  cau_side_t          side_q;
  logic [31:0]        d_q;
  logic [RW-1:0]      rem_r_q, rem_i_q;
  logic [QuoBits-1:0] q_r_q, q_i_q;

  // trial subtract of the shifted divisor
  always_comb begin
    dk      = RW'(d_i) << K;
    rem_r_d = rem_r_i;
    rem_i_d = rem_i_i;
    q_r_d   = q_r_i;
    q_i_d   = q_i_i;
    if (rem_r_i >= dk) begin
      rem_r_d  = rem_r_i - dk;
      q_r_d[K] = 1'b1;
    end
    if (rem_i_i >= dk) begin
      rem_i_d  = rem_i_i - dk;
      q_i_d[K] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q  <= side_i;
      d_q     <= d_i;
      rem_r_q <= rem_r_d;
      rem_i_q <= rem_i_d;
      q_r_q   <= q_r_d;
      q_i_q   <= q_i_d;
    end
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign d_o     = d_q;
  assign rem_r_o = rem_r_q;
  assign rem_i_o = rem_i_q;
  assign q_r_o   = q_r_q;
  assign q_i_o   = q_i_q;

endmodule

FILE: hdl/complex_arithmetic_unit.sv
`timescale 1ns / 1ps
// Pipeline: 3 front stages, 16 divider cells and 1 result register.
// Throughput: one request per cycle while the output is not stalled;
// the 16-cell divider chain sets the depth.
// Stalls freeze the whole pipeline while a result waits at the output.
// Reset (rst_ni low, async) clears all valid bits; payload is not reset.
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Complex add/sub/mul/div in signed Q8.8 with saturation and compare flags.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit import cau_pkg::*; #(
  parameter int unsigned FRAC_BITS = FracBitsDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  cau_req_t in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output cau_rsp_t out_data_o
);

  localparam int unsigned RW = (32 + FRAC_BITS > 48) ? 32 + FRAC_BITS : 48;

  logic en;
  logic out_valid_q;
  cau_rsp_t out_q, out_d;

  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  // chain wiring, index 0 is the front end output
  logic               v   [QuoBits+1];
  cau_side_t          sd  [QuoBits+1];
  logic [31:0]        dd  [QuoBits+1];
  logic [RW-1:0]      rr  [QuoBits+1];
  logic [RW-1:0]      ri  [QuoBits+1];
  logic [QuoBits-1:0] qr  [QuoBits+1];
  logic [QuoBits-1:0] qi  [QuoBits+1];

  cau_prep #(.FRAC_BITS(FRAC_BITS), .RW(RW)) u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .req_i   (in_data_i),
    .valid_o (v[0]),
    .side_o  (sd[0]),
    .d_o     (dd[0]),
    .rem_r_o (rr[0]),
    .rem_i_o (ri[0])
  );
  assign qr[0] = '0;
  assign qi[0] = '0;

  // divider cells, MSB first
  for (genvar g = 0; g < QuoBits; g++) begin : g_cell
    cau_div_cell #(.RW(RW), .K(QuoBits - 1 - g)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (v[g]),
      .side_i  (sd[g]),
      .d_i     (dd[g]),
      .rem_r_i (rr[g]),
      .rem_i_i (ri[g]),
      .q_r_i   (qr[g]),
      .q_i_i   (qi[g]),
      .valid_o (v[g+1]),
      .side_o  (sd[g+1]),
      .d_o     (dd[g+1]),
      .rem_r_o (rr[g+1]),
      .rem_i_o (ri[g+1]),
      .q_r_o   (qr[g+1]),
      .q_i_o   (qi[g+1])
    );
  end

  // sign, clip and select the result
  cau_side_t          s;
  logic signed [32:0] dvr, dvi;
  logic [16:0]        cr, ci;

  always_comb begin
    s   = sd[QuoBits];
    dvr = s.ovf_r ? (s.neg_r ? -33'sd65536 : 33'sd65536) :
          (s.neg_r ? -33'(qr[QuoBits]) : 33'(qr[QuoBits]));
    dvi = s.ovf_i ? (s.neg_i ? -33'sd65536 : 33'sd65536) :
          (s.neg_i ? -33'(qi[QuoBits]) : 33'(qi[QuoBits]));
    cr  = clip33(dvr);
    ci  = clip33(dvi);
    out_d.mag_less    = s.ml;
    out_d.mag_greater = s.mg;
    out_d.same_value  = s.eq;
    out_d.div_by_zero = s.dz;
    if (cau_op_e'(s.kind) != OP_DIV) begin
      out_d.res_real  = s.rr;
      out_d.res_imag  = s.ri;
      out_d.saturated = s.sat;
    end else if (s.dz) begin
      out_d.res_real  = '0;
      out_d.res_imag  = '0;
      out_d.saturated = 1'b0;
    end else begin
      out_d.res_real  = cr[15:0];
      out_d.res_imag  = ci[15:0];
      out_d.saturated = cr[16] | ci[16];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= v[QuoBits];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
